/* rtl/quadratic_bezier_point_generator_core_defines.svh */
// ---------------------------------------------------------------------------
// Quadratic Bezier point generator - assertion macros
// Shared concurrent assertion helpers for the RTL of this block.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_BEZIER_POINT_GENERATOR_CORE_DEFINES_SVH
`define QUADRATIC_BEZIER_POINT_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define QBPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qbpg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define QBPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qbpg: next-cycle check failed");

`endif

/* rtl/qbpg_pkg.sv */
// ---------------------------------------------------------------------------
// qbpg_pkg
// Types and constants shared by the quadratic Bezier point generator.
// ---------------------------------------------------------------------------
package qbpg_pkg;

  // Fixed field widths
  localparam int IDX_W = 6;  // point_index
  localparam int CNT_W = 7;  // points_per_curve register

  localparam logic [CNT_W-1:0] MIN_POINTS = 7'd3;
  localparam logic [CNT_W-1:0] PPC_RESET  = 7'd3;

  // Blend term being accumulated
  localparam logic [1:0] TERM_FIRST = 2'd0;
  localparam logic [1:0] TERM_MID   = 2'd1;
  localparam logic [1:0] TERM_END   = 2'd2;

  // Coordinate being computed
  localparam logic COORD_X = 1'b0;
  localparam logic COORD_Y = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQ_WAIT,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_EMIT
  } qbpg_state_e;

  // Multiply-accumulate request
  typedef struct packed {
    logic issue;  // a product enters the multiplier
    logic clear;  // this product starts a new sum
  } qbpg_mac_ctrl_t;

endpackage

/* rtl/quadratic_bezier_point_generator_core.sv */
// ---------------------------------------------------------------------------
// quadratic_bezier_point_generator_core
// Emits the points of a quadratic Bezier curve for each set of three
// control points, using one shared multiplier and one serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: three control points in signed 12.4.
//   m_axis returns points_per_curve points (values below 3 act as 3, above
//   MAX_POINTS as MAX_POINTS), in order; tlast marks the final point.
//   cfg_wr_en_i / cfg_wr_data_i write points_per_curve (reset value 3);
//   write it only while no curve is in progress.
// Timing:
//   s_axis_tready_o is high only while no curve is in progress.
//   The serial divider (one quotient bit per cycle, one division per
//   coordinate, AW = COORD_WIDTH + WW + 1 quotient bits with WW the width
//   of (MAX_POINTS-1)^2) sets the cost of each point.
// Reset: all control state clears, the register returns to 3, no output.
// Stall: a finished point waits in the output register; the sequencer
//   holds until that register is free, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "quadratic_bezier_point_generator_core_defines.svh"

module quadratic_bezier_point_generator_core #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // points_per_curve register
  input  logic                                    cfg_wr_en_i,
  input  logic [qbpg_pkg::CNT_W-1:0]              cfg_wr_data_i,
  // tdata: first_x, first_y, mid_x, mid_y, end_x, end_y (lowest bit up)
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  // tdata: curve_x, curve_y, point_index (lowest bit up); tlast: last_point
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [((2*COORD_WIDTH+qbpg_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                    m_axis_tlast_o
);
  import qbpg_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int WW    = $clog2((MAX_POINTS-1)*(MAX_POINTS-1) + 1);
  localparam int AW    = CW + WW + 1;
  localparam int OUT_W = ((2*CW+IDX_W+7)/8)*8;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  qbpg_state_e state_q, state_d;

  logic [CNT_W-1:0]     ppc_q;
  logic [CNT_W-1:0]     cnt_eff;
  logic signed [CW-1:0] pts_q [6];
  logic [IDX_W-1:0]     n_q;
  logic [IDX_W-1:0]     i_q;
  logic [IDX_W-1:0]     a_cur;
  logic [WW-1:0]        nsq_q;
  logic [WW-1:0]        a2_q;
  logic [WW-1:0]        i2_q;
  logic [WW-1:0]        wm;
  logic [WW:0]          wsum;
  logic [1:0]           k_q;
  logic                 coord_q;
  logic signed [CW-1:0] rx_q;
  logic                 last_pt;

  logic signed [CW-1:0] out_x_q;
  logic signed [CW-1:0] out_y_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic                 out_last_q;
  logic                 out_valid_q;

  qbpg_mac_ctrl_t       mac_ctrl;
  logic [WW-1:0]        term_w;
  logic [WW-1:0]        mac_w;
  logic signed [CW-1:0] mac_p;
  logic signed [AW-1:0] mac_acc;
  logic                 mac_busy;

  logic                 div_start;
  logic                 div_done;
  logic signed [CW-1:0] div_quot;

  logic                 in_acc;
  logic                 out_load;

  // Effective point count, clamped to [3, MAX_POINTS]
  always_comb begin
    priority if (ppc_q < MIN_POINTS) begin
      cnt_eff = MIN_POINTS;
    end else if (ppc_q > MAX_CNT) begin
      cnt_eff = MAX_CNT;
    end else begin
      cnt_eff = ppc_q;
    end
  end

  // Blend weights: (n-i)^2, 2(n-i)i = n^2 - (n-i)^2 - i^2, i^2
  assign a_cur   = n_q - i_q;
  assign wm      = nsq_q - a2_q - i2_q;
  assign wsum    = {1'b0, a2_q} + {1'b0, i2_q};
  assign last_pt = (i_q == n_q);

  always_comb begin
    unique case (k_q)
      TERM_FIRST: term_w = a2_q;
      TERM_MID:   term_w = wm;
      TERM_END:   term_w = i2_q;
      default:    term_w = '0;
    endcase
  end

  // Multiplier operands: n*n during setup, weight*control point otherwise
  assign mac_w = (state_q == ST_SQUARE) ? WW'(n_q) : term_w;
  assign mac_p = (state_q == ST_SQUARE) ? CW'(n_q) : pts_q[{k_q, coord_q}];

  qbpg_mac #(
    .CW (CW),
    .WW (WW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .weight_i (mac_w),
    .coord_i  (mac_p),
    .acc_o    (mac_acc),
    .busy_o   (mac_busy)
  );

  qbpg_div #(
    .CW (CW),
    .WW (WW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mac_acc),
    .den_i   (nsq_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_axis_tvalid_i) state_d = ST_SQUARE;
      ST_SQUARE:  state_d = ST_SQ_WAIT;
      ST_SQ_WAIT: if (!mac_busy) state_d = ST_MAC;
      ST_MAC:     if (k_q == TERM_END) state_d = ST_DRAIN;
      ST_DRAIN:   if (!mac_busy) state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = (coord_q == COORD_Y) ? ST_EMIT : ST_MAC;
      end
      ST_EMIT: begin
        if (out_load) state_d = last_pt ? ST_IDLE : ST_MAC;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mac_ctrl.issue  = (state_q == ST_SQUARE) || (state_q == ST_MAC);
    mac_ctrl.clear  = (state_q == ST_SQUARE) ||
                      ((state_q == ST_MAC) && (k_q == TERM_FIRST));
    div_start       = (state_q == ST_DRAIN) && !mac_busy;
    out_load        = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);
    s_axis_tready_o = (state_q == ST_IDLE);
    in_acc          = s_axis_tvalid_i && (state_q == ST_IDLE);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ppc_q       <= PPC_RESET;
      n_q         <= '0;
      i_q         <= '0;
      k_q         <= TERM_FIRST;
      coord_q     <= COORD_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        ppc_q <= cfg_wr_data_i;
      end
      if (in_acc) begin
        n_q <= IDX_W'(cnt_eff - 1'b1);
        i_q <= '0;
      end
      if ((state_q == ST_SQ_WAIT) && !mac_busy) begin
        i_q     <= '0;
        coord_q <= COORD_X;
      end
      if (state_q == ST_MAC) begin
        k_q <= (k_q == TERM_END) ? TERM_FIRST : k_q + 1'b1;
      end
      if (div_done && (state_q == ST_DIV) && (coord_q == COORD_X)) begin
        coord_q <= COORD_Y;
      end
      if (out_load) begin
        coord_q <= COORD_X;
        if (!last_pt) begin
          i_q <= i_q + 1'b1;
        end
      end
      // Output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and weight registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < 6; k++) begin
        pts_q[k] <= s_axis_tdata_i[k*CW +: CW];
      end
    end
    if ((state_q == ST_SQ_WAIT) && !mac_busy) begin
      nsq_q <= mac_acc[WW-1:0];
      a2_q  <= mac_acc[WW-1:0];
      i2_q  <= '0;
    end
    if (div_done && (state_q == ST_DIV) && (coord_q == COORD_X)) begin
      rx_q <= div_quot;
    end
    if (out_load) begin
      out_x_q    <= rx_q;
      out_y_q    <= div_quot;
      out_idx_q  <= i_q;
      out_last_q <= last_pt;
      if (!last_pt) begin
        // (a-1)^2 = a^2 - 2a + 1, (i+1)^2 = i^2 + 2i + 1
        a2_q <= a2_q - WW'({a_cur, 1'b0}) + 1'b1;
        i2_q <= i2_q + WW'({i_q, 1'b0}) + 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_idx_q, out_y_q, out_x_q});
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  `QBPG_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, state_q == ST_SQUARE)
  `QBPG_ASSERT_IMPL(a_div_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV)
  `QBPG_ASSERT_IMPL(a_weights_fit, clk_i, rst_ni, state_q == ST_MAC, wsum <= {1'b0, nsq_q})
  `QBPG_ASSERT_IMPL(a_index_range, clk_i, rst_ni, state_q != ST_IDLE, i_q <= n_q)
  `QBPG_ASSERT_IMPL(a_mid_curve_busy, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, state_q != ST_IDLE)

endmodule

/* rtl/qbpg_mac.sv */
// ---------------------------------------------------------------------------
// qbpg_mac
// Shared multiplier with registered product and a following accumulator.
// ---------------------------------------------------------------------------
module qbpg_mac #(
  parameter int CW = 16,
  parameter int WW = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qbpg_pkg::qbpg_mac_ctrl_t      ctrl_i,
  input  logic [WW-1:0]                 weight_i,
  input  logic signed [CW-1:0]          coord_i,
  output logic signed [CW+WW:0]         acc_o,
  output logic                          busy_o
);
  import qbpg_pkg::*;

  localparam int AW = CW + WW + 1;

  logic signed [AW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic                 pv_q;
  logic                 pclr_q;

  // Multiply stage: unsigned weight times signed coordinate
  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, weight_i}) * coord_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      pclr_q <= 1'b0;
    end else begin
      pv_q   <= ctrl_i.issue;
      pclr_q <= ctrl_i.clear;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      acc_q <= pclr_q ? prod_q : acc_q + prod_q;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = pv_q;

endmodule

/* rtl/qbpg_div.sv */
// ---------------------------------------------------------------------------
// qbpg_div
// Serial restoring divider, one quotient bit per cycle, with rounding to
// nearest (ties away from zero) and saturation to the coordinate range.
// ---------------------------------------------------------------------------
module qbpg_div #(
  parameter int CW = 16,
  parameter int WW = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [CW+WW:0] num_i,
  input  logic [WW-1:0]         den_i,
  output logic                  done_o,
  output logic signed [CW-1:0]  quot_o
);
  import qbpg_pkg::*;

  localparam int AW = CW + WW + 1;
  localparam int DW = $clog2(AW + 1);
  localparam logic [AW-1:0] POS_LIM = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [AW-1:0] NEG_LIM = POS_LIM + 1'b1;

  logic [AW-1:0] mag;
  logic [AW-1:0] dvd_q;
  logic [WW-1:0] rem_q;
  logic [WW-1:0] den_q;
  logic          neg_q;
  logic [DW-1:0] cnt_q;
  logic          done_q;
  logic [WW:0]   trial;
  logic          qbit;
  logic [WW:0]   rem_sub;

  // Magnitude plus half the divisor gives round-half-away-from-zero
  assign mag = (num_i[AW-1] ? AW'(-num_i) : AW'(num_i)) + AW'(den_i >> 1);

  // One restoring step
  assign trial   = {rem_q, dvd_q[AW-1]};
  assign qbit    = (trial >= {1'b0, den_q});
  assign rem_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == DW'(1));
      if (start_i) begin
        cnt_q <= DW'(AW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[AW-1];
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[AW-2:0], qbit};
      rem_q <= qbit ? rem_sub[WW-1:0] : trial[WW-1:0];
    end
  end

  // Sign restore and range guard
  always_comb begin
    if (neg_q) begin
      quot_o = (dvd_q > NEG_LIM) ? {1'b1, {(CW-1){1'b0}}} : CW'(-dvd_q);
    end else begin
      quot_o = (dvd_q > POS_LIM) ? {1'b0, {(CW-1){1'b1}}} : CW'(dvd_q);
    end
  end

  assign done_o = done_q;

endmodule
